@@ design/canned_waveform_generator_unit_defines.svh @@
// Assertion macros for the canned waveform generator RTL
`ifndef CANNED_WAVEFORM_GENERATOR_UNIT_DEFINES_SVH
`define CANNED_WAVEFORM_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low
`define CWG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low
`define CWG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/cwg_pkg.sv @@
// Types, constants and the sine table function of the canned waveform generator
package cwg_pkg;

  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int COUNT_BITS_DEF      = 24;
  localparam int CFG_IDX_W           = 3;

  // Register indexes of the write port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE, REG_POINT_COUNT, REG_START, REG_INTERVAL,
    REG_COEF_A, REG_COEF_B, REG_COEF_C, REG_COEF_D
  } cfg_reg_e;

  // Waveform modes; other codes give zero
  typedef enum logic [3:0] {
    MODE_IMPULSE   = 4'd0,
    MODE_STEP      = 4'd1,
    MODE_BOXCAR    = 4'd2,
    MODE_TRIANGLE  = 4'd3,
    MODE_SINE      = 4'd4,
    MODE_LINE      = 4'd5,
    MODE_QUADRATIC = 4'd6,
    MODE_CUBIC     = 4'd7,
    MODE_UNIT      = 4'd8
  } mode_e;

  // Register reset values
  localparam logic [3:0]  RST_MODE        = 4'd0;
  localparam logic [23:0] RST_POINT_COUNT = 24'd100;
  localparam logic [31:0] RST_START       = 32'd0;
  localparam logic [31:0] RST_INTERVAL    = 32'h0001_0000;
  localparam logic [31:0] RST_COEF_A      = 32'h0001_0000;
  localparam logic [31:0] RST_COEF_B      = 32'd0;
  localparam logic [31:0] RST_COEF_C      = 32'd0;
  localparam logic [31:0] RST_COEF_D      = 32'd0;

  localparam logic [31:0] UNIT_Q16 = 32'h0001_0000;

  typedef struct packed {
    logic [3:0]  mode;
    logic [23:0] point_count;
    logic [31:0] start_abscissa;
    logic [31:0] sample_interval;
    logic [31:0] coef_a;
    logic [31:0] coef_b;
    logic [31:0] coef_c;
    logic [31:0] coef_d;
  } cfg_t;

  // What the back end has to do with a sample
  typedef enum logic [2:0] {
    JOB_CONST, JOB_SINE, JOB_LINE, JOB_QUAD, JOB_CUBIC
  } job_kind_e;

  // word: finished value (const) or phase (sine); absc: x for polynomials
  typedef struct packed {
    job_kind_e   kind;
    logic [31:0] word;
    logic [31:0] absc;
    logic [23:0] index;
    logic        last;
  } job_t;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  // One quarter-wave entry, Q16.16; Taylor series in Horner form, evaluated at elaboration
  function automatic logic [16:0] sine_entry(int unsigned idx, int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (HALF_PI_Q30 * 64'(idx)) >> bits;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 156;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    return 17'((s + 64'd8192) >> 14);
  endfunction

endpackage

@@ design/cwg_if.sv @@
// Request and sample channel interfaces of the canned waveform generator

interface cwg_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface cwg_smp_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_value;
  logic [23:0] sample_index;
  logic        last_sample;
  modport source (output valid, output sample_value, output sample_index,
                  output last_sample, input ready);
  modport sink   (input valid, input sample_value, input sample_index,
                  input last_sample, output ready);
endinterface

@@ design/cwg_queue.sv @@
// Two-entry job queue between the front and back ends
module cwg_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  cwg_pkg::job_t  push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output cwg_pkg::job_t  pop_data_o
);

  cwg_pkg::job_t mem_q [2];
  logic [1:0]    count_q;
  logic          wr_q;
  logic          rd_q;
  logic          push;
  logic          pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      if (push && !pop) count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

endmodule

@@ design/cwg_front.sv @@
// Front end: takes requests, keeps the waveform state and classifies each sample
module cwg_front #(
  parameter int COUNT_BITS = cwg_pkg::COUNT_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cwg_pkg::cfg_t cfg_i,
  cwg_req_if.sink       req,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output cwg_pkg::job_t job_o
);

  localparam int CW        = ((COUNT_BITS > 25) ? COUNT_BITS : 25) + 1;
  localparam int DIV_STEPS = 48;
  // ceil(2^37/45) and ceil(2^25/45): exact quotients over the operand ranges used
  localparam logic [31:0] DEG_RECIP  = 32'd3054198967;
  localparam logic [19:0] FRAC_RECIP = 20'd745655;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL_A, F_MUL_B, F_DIV_DEG, F_DEG_FIN, F_DIV_RAMP, F_EMIT
  } state_e;

  state_e                 state_q;
  logic [COUNT_BITS-1:0]  cnt_q;
  logic [31:0]            absc_q;
  logic [31:0]            phase_q;
  logic [31:0]            pstep_q;
  logic [31:0]            ramp_q;
  logic [31:0]            rstep_q;
  logic                   fin_q;
  logic [47:0]            div_num_q;
  logic [24:0]            div_rem_q;
  logic [23:0]            div_den_q;
  logic [5:0]             div_cnt_q;
  logic                   bneg_q;
  logic [22:0]            n3_q;
  logic [26:0]            deg_quo_q;

  logic [23:0] n;
  logic [21:0] q4;
  logic [47:0] n3_prod;
  logic [CW-1:0] j_w, q3_w, q4_w;
  logic          last;
  logic          tri_up, tri_dn, is_tri;
  logic [31:0]   ramp_nxt;
  logic [32:0]   absc_sum;
  logic [31:0]   absc_nxt;
  logic [63:0]   mul_full;
  logic [31:0]   bmag;
  logic [63:0]   deg_prod;
  logic [31:0]   deg_rem_w;
  logic [18:0]   deg_frac_num;
  logic [39:0]   deg_frac_prod;
  logic [31:0]   deg_turns;
  logic [24:0]   div_t;
  logic          div_ge;
  logic [24:0]   div_rem_d;
  logic [47:0]   quo;
  logic          accept;

  // Point count, zero read as one, and the derived thresholds
  assign n       = (cfg_i.point_count == 24'd0) ? 24'd1 : cfg_i.point_count;
  assign q4      = n[23:2];
  assign n3_prod = 48'(n) * 48'h00_00AA_AAAB;
  assign j_w     = CW'(cnt_q);
  assign q3_w    = CW'(n3_q);
  assign q4_w    = CW'(q4);
  assign last    = (j_w >= CW'(n - 24'd1));

  // Triangle ramp windows
  assign is_tri   = (cfg_i.mode == cwg_pkg::MODE_TRIANGLE);
  assign tri_up   = (q4 != 22'd0) && (j_w > q4_w) && (j_w <= (q4_w << 1));
  assign tri_dn   = (q4 != 22'd0) && (j_w > (q4_w << 1)) && (j_w <= ((q4_w << 1) + q4_w));
  assign ramp_nxt = tri_up ? (ramp_q + rstep_q) : (ramp_q - rstep_q);

  // Saturating abscissa step
  assign absc_sum = {absc_q[31], absc_q} + {cfg_i.sample_interval[31], cfg_i.sample_interval};
  assign absc_nxt = (absc_sum[32] != absc_sum[31]) ?
                    (absc_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : absc_sum[31:0];

  // Phase products, low word only
  assign mul_full = cfg_i.coef_a *
                    ((state_q == F_MUL_A) ? cfg_i.start_abscissa : cfg_i.sample_interval);
  assign bmag     = cfg_i.coef_b[31] ? (32'd0 - cfg_i.coef_b) : cfg_i.coef_b;

  // Degrees to turns: (|b|*65536+180)/360 = 8192*(|b|/45) + (8192*(|b|%45)+22)/45
  assign deg_prod      = 64'(bmag) * 64'(DEG_RECIP);
  assign deg_rem_w     = bmag - (32'(deg_quo_q) * 32'd45);
  assign deg_frac_num  = {deg_rem_w[5:0], 13'd0} + 19'd22;
  assign deg_frac_prod = 40'(deg_frac_num) * 40'(FRAC_RECIP);
  assign deg_turns     = {deg_quo_q[18:0], 13'd0} + 32'(deg_frac_prod[37:25]);

  // Restoring divider for the ramp step, one quotient bit a cycle
  assign div_t     = {div_rem_q[23:0], div_num_q[47]};
  assign div_ge    = (div_t >= {1'b0, div_den_q});
  assign div_rem_d = div_ge ? (div_t - {1'b0, div_den_q}) : div_t;
  assign quo       = {div_num_q[46:0], div_ge};

  assign req.ready   = (state_q == F_IDLE);
  assign accept      = req.valid && req.ready;
  assign job_valid_o = (state_q == F_EMIT);

  // Classify the current sample
  always_comb begin
    job_o       = '0;
    job_o.kind  = cwg_pkg::JOB_CONST;
    job_o.absc  = absc_q;
    job_o.index = 24'(cnt_q);
    job_o.last  = last;
    unique case (cfg_i.mode)
      cwg_pkg::MODE_IMPULSE:
        job_o.word = (j_w == CW'((n - 24'd1) >> 1)) ? cwg_pkg::UNIT_Q16 : 32'd0;
      cwg_pkg::MODE_STEP:
        job_o.word = (j_w > CW'(n >> 1)) ? cwg_pkg::UNIT_Q16 : 32'd0;
      cwg_pkg::MODE_BOXCAR:
        job_o.word = ((j_w > q3_w) && (j_w <= (q3_w << 1))) ? cwg_pkg::UNIT_Q16 : 32'd0;
      cwg_pkg::MODE_TRIANGLE:
        job_o.word = (tri_up || tri_dn) ? ramp_nxt : 32'd0;
      cwg_pkg::MODE_SINE: begin
        job_o.kind = cwg_pkg::JOB_SINE;
        job_o.word = phase_q;
      end
      cwg_pkg::MODE_LINE:      job_o.kind = cwg_pkg::JOB_LINE;
      cwg_pkg::MODE_QUADRATIC: job_o.kind = cwg_pkg::JOB_QUAD;
      cwg_pkg::MODE_CUBIC:     job_o.kind = cwg_pkg::JOB_CUBIC;
      cwg_pkg::MODE_UNIT:
        job_o.word = (cnt_q == '0) ? cwg_pkg::UNIT_Q16 : 32'd0;
      default: job_o.word = 32'd0;
    endcase
  end

  // Boxcar third, recomputed every cycle
  always_ff @(posedge clk_i) begin
    n3_q <= n3_prod[47:25];
  end

  // Sequencer and waveform state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      cnt_q     <= '0;
      absc_q    <= 32'd0;
      phase_q   <= 32'd0;
      pstep_q   <= 32'd0;
      ramp_q    <= 32'd0;
      rstep_q   <= 32'd0;
      fin_q     <= 1'b1;
      div_num_q <= 48'd0;
      div_rem_q <= 25'd0;
      div_den_q <= 24'd0;
      div_cnt_q <= 6'd0;
      bneg_q    <= 1'b0;
      deg_quo_q <= 27'd0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            if (req.restart) begin
              cnt_q   <= '0;
              fin_q   <= 1'b0;
              absc_q  <= cfg_i.start_abscissa;
              ramp_q  <= 32'd0;
              state_q <= F_MUL_A;
            end else if (!fin_q) begin
              state_q <= F_EMIT;
            end
          end
        end
        F_MUL_A: begin
          phase_q <= mul_full[31:0];
          bneg_q  <= cfg_i.coef_b[31];
          state_q <= F_MUL_B;
        end
        F_MUL_B: begin
          pstep_q <= mul_full[31:0];
          state_q <= F_DIV_DEG;
        end
        F_DIV_DEG: begin
          deg_quo_q <= deg_prod[63:37];
          state_q   <= F_DEG_FIN;
        end
        F_DEG_FIN: begin
          phase_q <= phase_q + (bneg_q ? (32'd0 - deg_turns) : deg_turns);
          if (q4 != 22'd0) begin
            div_num_q <= 48'd65536 + 48'(q4 >> 1);
            div_rem_q <= 25'd0;
            div_den_q <= 24'(q4);
            div_cnt_q <= 6'd0;
            state_q   <= F_DIV_RAMP;
          end else begin
            rstep_q <= 32'd0;
            state_q <= F_EMIT;
          end
        end
        F_DIV_RAMP: begin
          div_num_q <= quo;
          div_rem_q <= div_rem_d;
          div_cnt_q <= div_cnt_q + 6'd1;
          if (div_cnt_q == 6'(DIV_STEPS - 1)) begin
            rstep_q <= quo[31:0];
            state_q <= F_EMIT;
          end
        end
        F_EMIT: begin
          if (job_ready_i) begin
            absc_q  <= absc_nxt;
            phase_q <= phase_q + pstep_q;
            if (is_tri && (tri_up || tri_dn)) ramp_q <= ramp_nxt;
            if (last) fin_q <= 1'b1;
            else cnt_q <= cnt_q + COUNT_BITS'(1);
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

@@ design/cwg_back.sv @@
// Back end: sine lookup and polynomial evaluation on a shared multiplier
module cwg_back #(
  parameter int SINE_TABLE_BITS = cwg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cwg_pkg::cfg_t cfg_i,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  cwg_pkg::job_t job_i,
  cwg_smp_if.source     smp
);

  localparam int TBL_N = 1 << SINE_TABLE_BITS;
  localparam int IDX_W = SINE_TABLE_BITS + 1;
  localparam logic signed [52:0] LIM = 53'sd1 << 50;

  typedef enum logic [2:0] {
    B_IDLE, B_SINE, B_SINE_FIN, B_PHI, B_PLO, B_ACC, B_DONE
  } state_e;

  state_e                 state_q;
  cwg_pkg::job_t          job_q;
  logic [31:0]            res_q;
  logic [16:0]            rom_q;
  logic                   sneg_q;
  logic signed [52:0]     h_q;
  logic [1:0]             pass_q;
  logic [1:0]             order_q;
  logic [50:0]            phi_q;
  logic [63:0]            plo_q;
  logic                   out_valid_q;
  logic [31:0]            out_value_q;
  logic [23:0]            out_index_q;
  logic                   out_last_q;

  logic [16:0]            sine_rom [TBL_N+1];
  logic [IDX_W-1:0]       idx;
  logic                   hneg, xneg;
  logic [52:0]            hm;
  logic [31:0]            xm;
  logic [31:0]            mul_a;
  logic [63:0]            mul_p;
  logic [64:0]            plo_rnd;
  logic [52:0]            m_raw, m;
  logic signed [52:0]     sm, coef, s, s_clamp;
  logic [31:0]            s_sat;
  logic                   final_pass;
  logic                   out_load;

  // Quarter-wave table, constant
  for (genvar g = 0; g <= TBL_N; g++) begin : g_rom
    assign sine_rom[g] = cwg_pkg::sine_entry(g, SINE_TABLE_BITS);
  end

  // Mirror the index in odd quadrants
  assign idx = job_q.word[30] ?
               (IDX_W'(TBL_N) - {1'b0, job_q.word[29 -: SINE_TABLE_BITS]}) :
               {1'b0, job_q.word[29 -: SINE_TABLE_BITS]};

  // Sign and magnitude of the operands
  assign hneg  = h_q[52];
  assign hm    = hneg ? (53'd0 - h_q) : h_q;
  assign xneg  = job_q.absc[31];
  assign xm    = xneg ? (32'd0 - job_q.absc) : job_q.absc;
  assign mul_a = (state_q == B_PHI) ? {13'd0, hm[50:32]} : hm[31:0];
  assign mul_p = 64'(mul_a) * 64'(xm);

  // Round to Q16.16, clamp the magnitude, restore sign, add coefficient
  assign plo_rnd = 65'(plo_q) + 65'd32768;
  assign m_raw   = {phi_q[36:0], 16'd0} + 53'(plo_rnd >> 16);
  assign m       = (|phi_q[50:34]) ? 53'(LIM) :
                   ((m_raw > 53'(LIM)) ? 53'(LIM) : m_raw);
  assign sm      = (hneg ^ xneg) ? -$signed(m) : $signed(m);
  always_comb begin
    unique case (pass_q)
      2'd0:    coef = 53'($signed(cfg_i.coef_b));
      2'd1:    coef = 53'($signed(cfg_i.coef_c));
      default: coef = 53'($signed(cfg_i.coef_d));
    endcase
  end
  assign s       = sm + coef;
  assign s_clamp = (s > LIM) ? LIM : ((s < -LIM) ? -LIM : s);
  assign s_sat   = (s > 53'sd2147483647) ? 32'h7FFF_FFFF :
                   ((s < -53'sd2147483648) ? 32'h8000_0000 : s[31:0]);
  assign final_pass = ((pass_q + 2'd1) == order_q);

  // Output register loads when the result is ready and the slot is free or draining
  assign out_load = (state_q == B_DONE) && (!out_valid_q || smp.ready);

  assign job_ready_o      = (state_q == B_IDLE);
  assign smp.valid        = out_valid_q;
  assign smp.sample_value = out_value_q;
  assign smp.sample_index = out_index_q;
  assign smp.last_sample  = out_last_q;

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      pass_q      <= 2'd0;
      order_q     <= 2'd0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (smp.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (job_valid_i) begin
            job_q  <= job_i;
            res_q  <= job_i.word;
            h_q    <= 53'($signed(cfg_i.coef_a));
            pass_q <= 2'd0;
            unique case (job_i.kind)
              cwg_pkg::JOB_SINE:  state_q <= B_SINE;
              cwg_pkg::JOB_LINE: begin
                order_q <= 2'd1;
                state_q <= B_PHI;
              end
              cwg_pkg::JOB_QUAD: begin
                order_q <= 2'd2;
                state_q <= B_PHI;
              end
              cwg_pkg::JOB_CUBIC: begin
                order_q <= 2'd3;
                state_q <= B_PHI;
              end
              default: state_q <= B_DONE;
            endcase
          end
        end
        B_SINE: begin
          rom_q   <= sine_rom[idx];
          sneg_q  <= job_q.word[31];
          state_q <= B_SINE_FIN;
        end
        B_SINE_FIN: begin
          res_q   <= sneg_q ? (32'd0 - 32'(rom_q)) : 32'(rom_q);
          state_q <= B_DONE;
        end
        B_PHI: begin
          phi_q   <= mul_p[50:0];
          state_q <= B_PLO;
        end
        B_PLO: begin
          plo_q   <= mul_p;
          state_q <= B_ACC;
        end
        B_ACC: begin
          if (final_pass) begin
            res_q   <= s_sat;
            state_q <= B_DONE;
          end else begin
            h_q     <= s_clamp;
            pass_q  <= pass_q + 2'd1;
            state_q <= B_PHI;
          end
        end
        B_DONE: begin
          if (out_load) begin
            out_value_q <= res_q;
            out_index_q <= job_q.index;
            out_last_q  <= job_q.last;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

@@ design/canned_waveform_generator_unit.sv @@
// Top level of the canned waveform generator: registers, front, queue, back
//
//  channel | direction | payload                                   | handshake
//  req     | in        | restart                                   | valid/ready
//  smp     | out       | sample_value, sample_index, last_sample   | valid/ready
//  cfg     | in        | cfg_idx_i, cfg_data_i                     | cfg_we_i
//
// Front end: a continuing request goes straight to F_EMIT; a restart runs F_MUL_A,
// F_MUL_B, F_DIV_DEG, F_DEG_FIN and, when point_count >= 4, the serial ramp-step
// divider (48 steps). Back end: table-free modes go to B_DONE, sine adds B_SINE and
// B_SINE_FIN; a Horner step makes two partial products on the shared 32x32 multiplier.
// A two-entry queue and the output register let either side stall on its own.
// Reset is asynchronous, active low; no clearing pass.
`include "canned_waveform_generator_unit_defines.svh"

module canned_waveform_generator_unit #(
  parameter int SINE_TABLE_BITS = cwg_pkg::SINE_TABLE_BITS_DEF,
  parameter int COUNT_BITS      = cwg_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cwg_req_if.sink                       req,
  cwg_smp_if.source                     smp,
  input  logic                          cfg_we_i,
  input  logic [cwg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_data_i
);

  cwg_pkg::cfg_t cfg_q;
  cwg_pkg::job_t job_push, job_pop;
  logic          job_push_valid, job_push_ready;
  logic          job_pop_valid, job_pop_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode            <= cwg_pkg::RST_MODE;
      cfg_q.point_count     <= cwg_pkg::RST_POINT_COUNT;
      cfg_q.start_abscissa  <= cwg_pkg::RST_START;
      cfg_q.sample_interval <= cwg_pkg::RST_INTERVAL;
      cfg_q.coef_a          <= cwg_pkg::RST_COEF_A;
      cfg_q.coef_b          <= cwg_pkg::RST_COEF_B;
      cfg_q.coef_c          <= cwg_pkg::RST_COEF_C;
      cfg_q.coef_d          <= cwg_pkg::RST_COEF_D;
    end else if (cfg_we_i) begin
      unique case (cwg_pkg::cfg_reg_e'(cfg_idx_i))
        cwg_pkg::REG_MODE:        cfg_q.mode            <= cfg_data_i[3:0];
        cwg_pkg::REG_POINT_COUNT: cfg_q.point_count     <= cfg_data_i[23:0];
        cwg_pkg::REG_START:       cfg_q.start_abscissa  <= cfg_data_i;
        cwg_pkg::REG_INTERVAL:    cfg_q.sample_interval <= cfg_data_i;
        cwg_pkg::REG_COEF_A:      cfg_q.coef_a          <= cfg_data_i;
        cwg_pkg::REG_COEF_B:      cfg_q.coef_b          <= cfg_data_i;
        cwg_pkg::REG_COEF_C:      cfg_q.coef_c          <= cfg_data_i;
        cwg_pkg::REG_COEF_D:      cfg_q.coef_d          <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cwg_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req         (req),
    .job_valid_o (job_push_valid),
    .job_ready_i (job_push_ready),
    .job_o       (job_push)
  );

  cwg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_push_valid),
    .push_ready_o (job_push_ready),
    .push_data_i  (job_push),
    .pop_valid_o  (job_pop_valid),
    .pop_ready_i  (job_pop_ready),
    .pop_data_o   (job_pop)
  );

  cwg_back #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_pop_valid),
    .job_ready_o (job_pop_ready),
    .job_i       (job_pop),
    .smp         (smp)
  );

  // Front end only hands on a sample while it is busy with a request
  `CWG_ASSERT_IMP(a_push_while_busy, job_push_valid, !req.ready, "job pushed while front idle")
  // A restart keeps the front busy with its set-up
  `CWG_ASSERT_NXT(a_restart_busy, req.valid && req.ready && req.restart, !req.ready, "restart not held")
  // Back end works on one job at a time
  `CWG_ASSERT_NXT(a_back_single, job_pop_valid && job_pop_ready, !job_pop_ready, "back took two jobs")

endmodule

@@ bench/canned_waveform_generator_unit_checker.sv @@
// Sample predictor and scoreboard for the canned waveform generator
module canned_waveform_generator_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic        req_restart_i,
  input  logic        smp_valid_i,
  input  logic        smp_ready_i,
  input  logic [31:0] smp_value_i,
  input  logic [23:0] smp_index_i,
  input  logic        smp_last_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          sample_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_N = 1 << cwg_pkg::SINE_TABLE_BITS_DEF;
  localparam longint WIDE_LIM = 64'sd1 << 50;

  typedef struct packed {
    logic [31:0] value;
    logic [23:0] index;
    logic        last;
  } sample_t;

  sample_t expected_samples[$];

  // shadow registers
  logic [3:0]  mode_q;
  logic [23:0] count_q;
  logic [31:0] start_q, interval_q, ca_q, cb_q, cc_q, cd_q;
  // shadow generator state
  logic [23:0] counter_q;
  logic [31:0] absc_q, phase_q, phase_step_q, ramp_q, ramp_step_q;
  logic        done_q;
  longint      quarter_wave[TBL_N+1];

  assign pending_o = expected_samples.size();

  initial begin
    longint x, x2, t, s;
    int k;
    longint divs[6];
    divs = '{156, 110, 72, 42, 20, 6};
    for (int i = 0; i <= TBL_N; i++) begin
      x  = (64'd1686629713 * i) / TBL_N;
      x2 = (x * x) >>> 30;
      t  = 64'd1 << 30;
      for (k = 0; k < 6; k++) t = (64'd1 << 30) - ((x2 * t) >>> 30) / divs[k];
      s  = (x * t) >>> 30;
      quarter_wave[i] = (s + 8192) >>> 14;
    end
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_wide(longint v);
    if (v > WIDE_LIM) return WIDE_LIM;
    if (v < -WIDE_LIM) return -WIDE_LIM;
    return v;
  endfunction

  // Q16.16 product, rounded half away from zero, magnitude clamped
  function automatic longint mul_q16(longint h, longint x);
    logic        neg;
    logic [63:0] hm, xm, phi, plo, m;
    neg = (h < 0) != (x < 0);
    hm  = h < 0 ? -h : h;
    xm  = x < 0 ? -x : x;
    phi = (hm >> 32) * xm;
    plo = (hm & 64'hFFFF_FFFF) * xm;
    if (phi >= (64'd1 << 34)) m = WIDE_LIM;
    else begin
      m = (phi << 16) + ((plo + 64'd32768) >> 16);
      if (m > WIDE_LIM) m = WIDE_LIM;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sine_at(logic [31:0] ph);
    int unsigned idx;
    idx = (ph >> (30 - cwg_pkg::SINE_TABLE_BITS_DEF)) & (TBL_N - 1);
    if (ph[30]) idx = TBL_N - idx;
    return ph[31] ? -quarter_wave[idx] : quarter_wave[idx];
  endfunction

  function automatic logic [31:0] degrees_to_phase(logic [31:0] b);
    longint bs;
    logic [63:0] mag;
    logic [31:0] q;
    bs  = longint'(signed'(b));
    mag = bs < 0 ? -bs : bs;
    q   = 32'((mag * 65536 + 180) / 360);
    return bs < 0 ? -q : q;
  endfunction

  // Works out the next sample for one accepted request
  task automatic predict_sample(input logic restart);
    int unsigned n, j, q;
    longint v, x, h;
    logic last;
    sample_t s;
    n = count_q == 0 ? 1 : count_q;
    if (restart) begin
      q = n / 4;
      counter_q    = '0;
      done_q       = 1'b0;
      absc_q       = start_q;
      phase_q      = 32'(longint'(signed'(ca_q)) * longint'(signed'(start_q)))
                     + degrees_to_phase(cb_q);
      phase_step_q = 32'(longint'(signed'(ca_q)) * longint'(signed'(interval_q)));
      ramp_q       = '0;
      ramp_step_q  = q != 0 ? (65536 + q / 2) / q : 0;
    end else if (done_q) begin
      return;
    end
    j = counter_q;
    x = longint'(signed'(absc_q));
    v = 0;
    case (mode_q)
      cwg_pkg::MODE_IMPULSE: v = (j == (n - 1) / 2) ? 65536 : 0;
      cwg_pkg::MODE_STEP:    v = (j > n / 2) ? 65536 : 0;
      cwg_pkg::MODE_BOXCAR: begin
        q = n / 3;
        v = (j > q && j <= 2 * q) ? 65536 : 0;
      end
      cwg_pkg::MODE_TRIANGLE: begin
        q = n / 4;
        if (q != 0 && j > q && j <= 2 * q) begin
          ramp_q = ramp_q + ramp_step_q;
          v = longint'(signed'(ramp_q));
        end else if (q != 0 && j > 2 * q && j <= 3 * q) begin
          ramp_q = ramp_q - ramp_step_q;
          v = longint'(signed'(ramp_q));
        end
      end
      cwg_pkg::MODE_SINE: v = sine_at(phase_q);
      cwg_pkg::MODE_LINE: v = sat32(mul_q16(signed'(ca_q), x) + signed'(cb_q));
      cwg_pkg::MODE_QUADRATIC: begin
        h = clamp_wide(mul_q16(signed'(ca_q), x) + signed'(cb_q));
        v = sat32(mul_q16(h, x) + signed'(cc_q));
      end
      cwg_pkg::MODE_CUBIC: begin
        h = clamp_wide(mul_q16(signed'(ca_q), x) + signed'(cb_q));
        h = clamp_wide(mul_q16(h, x) + signed'(cc_q));
        v = sat32(mul_q16(h, x) + signed'(cd_q));
      end
      cwg_pkg::MODE_UNIT: v = (j == 0) ? 65536 : 0;
      default: v = 0;
    endcase
    last = j >= n - 1;
    s.value = v[31:0];
    s.index = j[23:0];
    s.last  = last;
    expected_samples.push_back(s);
    absc_q  = 32'(sat32(x + longint'(signed'(interval_q))));
    phase_q = phase_q + phase_step_q;
    if (last) done_q = 1'b1;
    else counter_q = counter_q + 24'd1;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
    fail_count_o++;
  endtask

  // Watch the register port and both channels
  always @(posedge clk_i or negedge rst_ni) begin
    sample_t e;
    if (!rst_ni) begin
      mode_q = cwg_pkg::RST_MODE; count_q = cwg_pkg::RST_POINT_COUNT;
      start_q = cwg_pkg::RST_START; interval_q = cwg_pkg::RST_INTERVAL;
      ca_q = cwg_pkg::RST_COEF_A; cb_q = cwg_pkg::RST_COEF_B;
      cc_q = cwg_pkg::RST_COEF_C; cd_q = cwg_pkg::RST_COEF_D;
      counter_q = '0; absc_q = '0; phase_q = '0; phase_step_q = '0;
      ramp_q = '0; ramp_step_q = '0; done_q = 1'b1;
      fail_count_o = 0;
      sample_count_o = 0;
      expected_samples.delete();
    end else begin
      if (cfg_we_i) begin
        case (cwg_pkg::cfg_reg_e'(cfg_idx_i))
          cwg_pkg::REG_MODE:        mode_q = cfg_data_i[3:0];
          cwg_pkg::REG_POINT_COUNT: count_q = cfg_data_i[23:0];
          cwg_pkg::REG_START:       start_q = cfg_data_i;
          cwg_pkg::REG_INTERVAL:    interval_q = cfg_data_i;
          cwg_pkg::REG_COEF_A:      ca_q = cfg_data_i;
          cwg_pkg::REG_COEF_B:      cb_q = cfg_data_i;
          cwg_pkg::REG_COEF_C:      cc_q = cfg_data_i;
          cwg_pkg::REG_COEF_D:      cd_q = cfg_data_i;
          default: ;
        endcase
      end
      if (smp_valid_i && smp_ready_i) begin
        sample_count_o++;
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected sample", smp_value_i, 32'h0);
        end else begin
          e = expected_samples.pop_front();
          if (smp_value_i !== e.value) report_mismatch("value", smp_value_i, e.value);
          if (smp_index_i !== e.index) report_mismatch("index", smp_index_i, e.index);
          if (smp_last_i !== e.last) report_mismatch("last", smp_last_i, e.last);
        end
      end
      if (req_valid_i && req_ready_i) predict_sample(req_restart_i);
    end
  end
endmodule

@@ bench/canned_waveform_generator_unit_tb.sv @@
// Stimulus and verdict for the canned waveform generator
module canned_waveform_generator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          fail_count, pending, sample_count;
  int          requests_sent = 0;
  bit          long_hold = 1'b0;

  cwg_req_if req ();
  cwg_smp_if smp ();

  initial begin
    req.valid = 1'b0;
    req.restart = 1'b0;
    smp.ready = 1'b0;
  end

  canned_waveform_generator_unit DUT (
    .clk_i, .rst_ni, .req(req.sink), .smp(smp.source), .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  canned_waveform_generator_unit_checker u_checker (
    .clk_i, .rst_ni,
    .req_valid_i(req.valid), .req_ready_i(req.ready), .req_restart_i(req.restart),
    .smp_valid_i(smp.valid), .smp_ready_i(smp.ready), .smp_value_i(smp.sample_value),
    .smp_index_i(smp.sample_index), .smp_last_i(smp.last_sample),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .sample_count_o(sample_count)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  initial begin
    #20ms;
    $display("timeout with %0d samples outstanding", pending);
    $display("TB_ERROR");
    $finish;
  end

  // Sample sink: random stalls, one long hold-off
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        smp.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        long_hold = 1'b0;
      end else begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (w != 0) begin
          smp.ready <= 1'b0;
          repeat (w) @(negedge clk_i);
        end
        smp.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input cwg_pkg::cfg_reg_e idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One request with a random gap ahead of it; valid stays up until the next gap or drain
  task automatic send_request(input logic restart, input bit no_gap);
    int w;
    w = no_gap ? 0 : $urandom_range(0, 8);
    if (w != 0) begin
      req.valid <= 1'b0;
      repeat (w) @(negedge clk_i);
    end
    req.valid <= 1'b1;
    req.restart <= restart;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    @(negedge clk_i);
    requests_sent++;
  endtask

  // Back to idle: all samples in, then a margin for the back end
  task automatic drain();
    req.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      default: return $urandom;
    endcase
  endfunction

  // One waveform of n samples, sometimes with noise or a cut-short run
  task automatic run_waveform(input logic [3:0] m, input logic [23:0] n, input bit no_gap);
    int extra;
    write_reg(cwg_pkg::REG_MODE, 32'(m));
    write_reg(cwg_pkg::REG_POINT_COUNT, 32'(n));
    send_request(1'b1, no_gap);
    extra = (n == 0) ? 0 : n - 1;
    if ($urandom_range(0, 9) == 0) extra = $urandom_range(0, extra);
    repeat (extra) send_request(1'b0, no_gap);
    if ($urandom_range(0, 4) == 0) send_request(1'b0, no_gap);
    drain();
  endtask

  initial begin
    logic [23:0] n;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: idle continue, impulse, step, triangle, boxcar, mode 15; short lengths
    send_request(1'b0, 1'b0);
    drain();
    run_waveform(cwg_pkg::MODE_IMPULSE, 24'd5, 1'b0);
    run_waveform(cwg_pkg::MODE_STEP, 24'd0, 1'b0);
    run_waveform(cwg_pkg::MODE_TRIANGLE, 24'd3, 1'b0);
    run_waveform(cwg_pkg::MODE_TRIANGLE, 24'd9, 1'b0);
    run_waveform(cwg_pkg::MODE_BOXCAR, 24'd7, 1'b0);
    run_waveform(4'd15, 24'd2, 1'b0);

    // Sender keeps offering while the sink holds off
    long_hold = 1'b1;
    run_waveform(cwg_pkg::MODE_UNIT, 24'd40, 1'b1);

    // Random phases across modes and coefficients
    while (requests_sent < 1150) begin
      write_reg(cwg_pkg::REG_START, rand_word());
      write_reg(cwg_pkg::REG_INTERVAL, rand_word());
      write_reg(cwg_pkg::REG_COEF_A, rand_word());
      write_reg(cwg_pkg::REG_COEF_B, rand_word());
      write_reg(cwg_pkg::REG_COEF_C, rand_word());
      write_reg(cwg_pkg::REG_COEF_D, rand_word());
      n = ($urandom_range(0, 30) == 0) ? 24'hFFFFFF : 24'($urandom_range(1, 24));
      if (n == 24'hFFFFFF) begin
        // largest count: start it, then cut it short by lowering the count
        write_reg(cwg_pkg::REG_MODE, 32'($urandom_range(0, 15)));
        write_reg(cwg_pkg::REG_POINT_COUNT, 32'(n));
        send_request(1'b1, 1'b0);
        repeat (4) send_request(1'b0, 1'b0);
        drain();
        write_reg(cwg_pkg::REG_POINT_COUNT, 32'd1);
        send_request(1'b0, 1'b0);
        drain();
      end else begin
        run_waveform(4'($urandom_range(0, 15)), n, $urandom_range(0, 3) == 0);
      end
    end

    drain();
    $display("%0d requests sent, %0d samples checked over all modes, lengths and stalls",
             requests_sent, sample_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
